// ===== hw/rtl/first_fit_vertex_recolor_defines.svh =====
// Assertion helpers shared by the RTL files.
`ifndef FIRST_FIT_VERTEX_RECOLOR_DEFINES_SVH
`define FIRST_FIT_VERTEX_RECOLOR_DEFINES_SVH

// Condition holds in the same cycle.
`define FFVR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Condition holds in the following cycle.
`define FFVR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/ffvr_pkg.sv =====
`timescale 1ns / 1ps

package ffvr_pkg;

   localparam int COLOR_W            = 6;
   localparam int COUNT_W            = 6;
   localparam int MAP_W              = 1 << COLOR_W;
   localparam int CHUNK_W            = 8;
   localparam int CHUNK_SEL_W        = $clog2(MAP_W / CHUNK_W);
   localparam int POS_W              = $clog2(CHUNK_W);
   localparam int MAX_DEGREE_DEFAULT = 63;

   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 8;

   typedef struct packed {
      logic load;
      logic search;
      logic read_first;
      logic advance;
   } cmd_type;

   typedef struct packed {
      logic found;
      logic empty;
      logic last_result;
   } status_type;

endpackage

// ===== hw/rtl/ffvr_ram.sv =====
`timescale 1ns / 1ps

module ffvr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/ffvr_datapath.sv =====
`timescale 1ns / 1ps
`include "first_fit_vertex_recolor_defines.svh"

module ffvr_datapath
   import ffvr_pkg::*;
#(
   parameter int MAX_DEGREE = MAX_DEGREE_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   input  logic [COLOR_W-1:0] current_color,
   input  logic [COLOR_W-1:0] neighbor_color,
   input  logic               has_neighbor,
   output status_type         status,
   output logic [COLOR_W-1:0] new_color,
   output logic               changed,
   output logic               reschedule,
   output logic               neighbor_valid
);

   localparam int ADDR_W = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;

   logic [MAP_W-1:0]       taken_ff;
   logic [COUNT_W-1:0]     count_ff;
   logic [COLOR_W-1:0]     held_ff;
   logic [CHUNK_SEL_W-1:0] chunk_ff;
   logic [COLOR_W-1:0]     new_color_ff;
   logic                   changed_ff;
   logic [COUNT_W-1:0]     k_ff;

   logic                   store_en;
   logic [CHUNK_W-1:0]     free_bits;
   logic                   found;
   logic [POS_W-1:0]       pos;
   logic [COLOR_W-1:0]     found_color;
   logic [COUNT_W-1:0]     k_next;
   logic                   last_result;
   logic                   empty;
   logic                   rd_en;
   logic [ADDR_W-1:0]      rd_addr;
   logic [COLOR_W-1:0]     rd_color;

   assign store_en  = cmd.load && has_neighbor && (count_ff < COUNT_W'(MAX_DEGREE));
   assign free_bits = ~taken_ff[{chunk_ff, {POS_W{1'b0}}} +: CHUNK_W];
   assign found     = |free_bits;

   always_comb begin
      pos = '0;
      for (int i = CHUNK_W - 1; i >= 0; i--) begin
         if (free_bits[i]) begin
            pos = POS_W'(i);
         end
      end
   end

   assign found_color = {chunk_ff, pos};
   assign empty       = (count_ff == '0);
   assign k_next      = k_ff + COUNT_W'(1);
   assign last_result = empty || (k_next == count_ff);

   assign rd_en   = cmd.read_first || (cmd.advance && !last_result);
   assign rd_addr = cmd.read_first ? '0 : k_next[ADDR_W-1:0];

   ffvr_ram #(
      .WIDTH(COLOR_W),
      .DEPTH(MAX_DEGREE)
   ) u_store (
      .clock  (clock),
      .wr_en  (store_en),
      .wr_addr(count_ff[ADDR_W-1:0]),
      .wr_data(neighbor_color),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_color)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         taken_ff <= '0;
         count_ff <= '0;
         held_ff  <= '0;
         chunk_ff <= '0;
      end else begin
         if (cmd.load) begin
            held_ff  <= current_color;
            chunk_ff <= '0;
         end
         if (store_en) begin
            taken_ff[neighbor_color] <= 1'b1;
            count_ff                 <= count_ff + COUNT_W'(1);
         end
         if (cmd.search) begin
            if (found) begin
               taken_ff <= '0;
            end else begin
               chunk_ff <= chunk_ff + CHUNK_SEL_W'(1);
            end
         end
         if (cmd.advance && last_result) begin
            count_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.search && found) begin
         new_color_ff <= found_color;
         changed_ff   <= (found_color != held_ff);
      end
      if (cmd.read_first) begin
         k_ff <= '0;
      end else if (cmd.advance) begin
         k_ff <= k_next;
      end
   end

   assign status.found       = found;
   assign status.empty       = empty;
   assign status.last_result = last_result;

   assign new_color      = new_color_ff;
   assign changed        = changed_ff;
   assign neighbor_valid = !empty;
   assign reschedule     = changed_ff && !empty && (rd_color >= new_color_ff);

   `FFVR_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= COUNT_W'(MAX_DEGREE), "neighbor count beyond capacity")
   `FFVR_ASSERT_NEXT(a_map_cleared, clock, reset, cmd.search && found, taken_ff == '0, "taken map not cleared after search")

endmodule

// ===== hw/rtl/ffvr_ctrl.sv =====
`timescale 1ns / 1ps
`include "first_fit_vertex_recolor_defines.svh"

module ffvr_ctrl
   import ffvr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tlast,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [1:0] {
      S_COLLECT,
      S_SEARCH,
      S_READ,
      S_EMIT
   } state_type;

   state_type state_ff;
   logic      req_tready_ff;
   logic      rsp_tvalid_ff;

   assign cmd.load       = req_tready_ff && req_tvalid;
   assign cmd.search     = (state_ff == S_SEARCH);
   assign cmd.read_first = (state_ff == S_READ);
   assign cmd.advance    = rsp_tvalid_ff && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_COLLECT;
         req_tready_ff <= 1'b1;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_COLLECT: begin
               if (cmd.load && req_tlast) begin
                  state_ff      <= S_SEARCH;
                  req_tready_ff <= 1'b0;
               end
            end
            S_SEARCH: begin
               if (status.found) begin
                  if (status.empty) begin
                     state_ff      <= S_EMIT;
                     rsp_tvalid_ff <= 1'b1;
                  end else begin
                     state_ff <= S_READ;
                  end
               end
            end
            S_READ: begin
               state_ff      <= S_EMIT;
               rsp_tvalid_ff <= 1'b1;
            end
            S_EMIT: begin
               if (cmd.advance && status.last_result) begin
                  state_ff      <= S_COLLECT;
                  rsp_tvalid_ff <= 1'b0;
                  req_tready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff      <= S_COLLECT;
               req_tready_ff <= 1'b1;
               rsp_tvalid_ff <= 1'b0;
            end
         endcase
      end
   end

   assign req_tready = req_tready_ff;
   assign rsp_tvalid = rsp_tvalid_ff;

   `FFVR_ASSERT_SAME(a_one_side, clock, reset, rsp_tvalid_ff, !req_tready_ff, "request and response open together")
   `FFVR_ASSERT_NEXT(a_close_vertex, clock, reset, cmd.load && req_tlast, !req_tready_ff && !rsp_tvalid_ff, "vertex close did not start search")
   `FFVR_ASSERT_NEXT(a_reopen, clock, reset, cmd.advance && status.last_result, req_tready_ff && !rsp_tvalid_ff, "input not reopened after final response")

endmodule

// ===== hw/rtl/first_fit_vertex_recolor.sv =====
`timescale 1ns / 1ps

// First-fit recoloring of one graph vertex. Stream the vertex's neighbor colors in, one
// request per cycle while req_tready is high, with tlast on the final request; tuser says
// whether the request carries a neighbor. After tlast the block scans the taken-color map
// eight colors per cycle, one group of eight at a time from color 0 up to the chosen color,
// reads the first entry of the neighbor store when there are neighbors, then returns one
// response per stored neighbor (or one response for a vertex without neighbors) at one per
// cycle while rsp_tready is high, tlast marking the final one. No request is taken while
// its responses are pending. Neighbors past MAX_DEGREE are ignored.

module first_fit_vertex_recolor
   import ffvr_pkg::*;
#(
   parameter int MAX_DEGREE = MAX_DEGREE_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // current_color[5:0], neighbor_color[11:6], zero
   input  logic                   req_tuser,  // has_neighbor
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // new_color[5:0], changed[6], reschedule[7]
   output logic                   rsp_tuser,  // neighbor_valid
   output logic                   rsp_tlast
);

   cmd_type            cmd;
   status_type         status;
   logic [COLOR_W-1:0] new_color;
   logic               changed;
   logic               reschedule;

   ffvr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tlast (req_tlast),
      .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .status    (status),
      .cmd       (cmd)
   );

   ffvr_datapath #(
      .MAX_DEGREE(MAX_DEGREE)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .current_color (req_tdata[COLOR_W-1:0]),
      .neighbor_color(req_tdata[2*COLOR_W-1:COLOR_W]),
      .has_neighbor  (req_tuser),
      .status        (status),
      .new_color     (new_color),
      .changed       (changed),
      .reschedule    (reschedule),
      .neighbor_valid(rsp_tuser)
   );

   assign rsp_tdata = {reschedule, changed, new_color};
   assign rsp_tlast = status.last_result;

endmodule

// ===== tb/first_fit_vertex_recolor_tb.sv =====
`timescale 1ns / 1ps

module first_fit_vertex_recolor_tb;
   import ffvr_pkg::*;

   localparam int STALL_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 2 * MAX_DEGREE_DEFAULT + 40;

   typedef struct packed {
      logic [COLOR_W-1:0] new_color;
      logic               changed;
      logic               reschedule;
      logic               neighbor_valid;
      logic               end_of_run;
   } recolor_result_type;

   typedef struct packed {
      logic [COLOR_W-1:0] cur;
      logic [COLOR_W-1:0] nc;
      logic               hn;
   } vertex_item_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tuser  = 1'b0;
   logic                   req_tlast  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;

   recolor_result_type expected_results[$];
   vertex_item_type    vertex_items[$];
   recolor_result_type oldest_result;
   logic [MAP_W-1:0]   taken_map = '0;
   logic [COLOR_W-1:0] stored_colors[MAX_DEGREE_DEFAULT];
   int                 stored_count = 0;
   logic [COLOR_W-1:0] last_color   = '0;
   int                 error_count  = 0;
   int                 items_sent   = 0;
   int                 stall_cycles = 0;
   int                 ready_left   = 0;
   logic               calm         = 1'b0;

   first_fit_vertex_recolor u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   task automatic predict_recolor(input logic [COLOR_W-1:0] cur, input logic [COLOR_W-1:0] nc,
                                  input logic hn, input logic lst);
      logic [COLOR_W-1:0] fresh;
      logic               moved;
      recolor_result_type r;
      int                 c;
      last_color = cur;
      if (hn && stored_count < MAX_DEGREE_DEFAULT) begin
         taken_map[nc]               = 1'b1;
         stored_colors[stored_count] = nc;
         stored_count++;
      end
      if (lst) begin
         fresh = COLOR_W'(stored_count);
         for (c = stored_count; c >= 0; c--) begin
            if (!taken_map[c]) fresh = COLOR_W'(c);
         end
         moved = (fresh != last_color);
         if (stored_count == 0) begin
            r.new_color      = fresh;
            r.changed        = moved;
            r.reschedule     = 1'b0;
            r.neighbor_valid = 1'b0;
            r.end_of_run     = 1'b1;
            expected_results.push_back(r);
         end else begin
            for (c = 0; c < stored_count; c++) begin
               r.new_color      = fresh;
               r.changed        = moved;
               r.reschedule     = moved && (stored_colors[c] >= fresh);
               r.neighbor_valid = 1'b1;
               r.end_of_run     = (c == stored_count - 1);
               expected_results.push_back(r);
            end
         end
         taken_map    = '0;
         stored_count = 0;
      end
   endtask

   task automatic send_request(input logic [COLOR_W-1:0] cur, input logic [COLOR_W-1:0] nc,
                               input logic hn, input logic lst);
      int gap;
      gap = 0;
      if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 11);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0000, nc, cur};
      req_tuser  <= hn;
      req_tlast  <= lst;
      do @(posedge clock); while (!req_tready);
      predict_recolor(cur, nc, hn, lst);
      items_sent++;
   endtask

   task automatic add_item(input logic [COLOR_W-1:0] cur, input logic [COLOR_W-1:0] nc,
                           input logic hn);
      vertex_item_type it;
      it.cur = cur;
      it.nc  = nc;
      it.hn  = hn;
      vertex_items.push_back(it);
   endtask

   task automatic send_vertex();
      int i;
      for (i = 0; i < vertex_items.size(); i++) begin
         send_request(vertex_items[i].cur, vertex_items[i].nc, vertex_items[i].hn,
                      i == vertex_items.size() - 1);
      end
      vertex_items.delete();
   endtask

   task automatic hold_until_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
   endtask

   // mostly well-formed vertices of small degree, with colors packed near the degree
   task automatic build_random_vertex();
      int                 degree;
      int                 span;
      int                 i;
      int                 r;
      logic [COLOR_W-1:0] cur;
      r = $urandom_range(0, 19);
      if (r == 0) degree = 0;
      else if (r < 16) degree = $urandom_range(1, 6);
      else degree = $urandom_range(7, 20);
      span = ($urandom_range(0, 3) == 0) ? 63 : degree + 1;
      cur  = ($urandom_range(0, 1) == 0) ? COLOR_W'($urandom_range(0, span))
                                         : COLOR_W'($urandom());
      for (i = 0; i < degree; i++) begin
         if ($urandom_range(0, 5) == 0) add_item(cur, COLOR_W'($urandom()), 1'b0);
         add_item(cur, COLOR_W'($urandom_range(0, span)), 1'b1);
      end
      if (degree == 0) begin
         r = $urandom_range(1, 3);
         for (i = 0; i < r; i++) add_item(cur, COLOR_W'($urandom()), 1'b0);
      end else if ($urandom_range(0, 5) == 0) begin
         add_item(cur, COLOR_W'($urandom()), 1'b0);
      end
      if ($urandom_range(0, 7) == 0) begin
         vertex_items[vertex_items.size() - 1].cur = COLOR_W'($urandom());
      end
   endtask

   task automatic run_empty_vertices();
      add_item(6'd0, 6'd0, 1'b0);
      send_vertex();
      add_item(6'd63, 6'd63, 1'b0);
      send_vertex();
      add_item(6'd5, 6'd42, 1'b0);
      add_item(6'd5, 6'd21, 1'b0);
      add_item(6'd0, 6'd63, 1'b0);
      send_vertex();
   endtask

   task automatic run_single_neighbors();
      add_item(6'd1, 6'd0, 1'b1);
      send_vertex();
      add_item(6'd0, 6'd63, 1'b1);
      send_vertex();
      add_item(6'd0, 6'd0, 1'b1);
      send_vertex();
      add_item(6'd1, 6'd1, 1'b1);
      send_vertex();
      add_item(6'd63, 6'd63, 1'b1);
      send_vertex();
   endtask

   task automatic run_skipped_neighbors();
      add_item(6'd3, 6'd0, 1'b1);
      add_item(6'd3, 6'd1, 1'b0);
      add_item(6'd2, 6'd2, 1'b1);
      send_vertex();
      add_item(6'd7, 6'd4, 1'b1);
      add_item(6'd7, 6'd9, 1'b0);
      send_vertex();
   endtask

   // full degree covers 0..62, so the only free color is 63; extras past the limit are dropped
   task automatic run_degree_overflow();
      int i;
      for (i = 0; i < MAX_DEGREE_DEFAULT; i++) add_item(6'd63, COLOR_W'(i), 1'b1);
      add_item(6'd63, 6'd63, 1'b1);
      add_item(6'd63, 6'd5, 1'b1);
      add_item(6'd63, 6'd0, 1'b1);
      send_vertex();
      for (i = 0; i < MAX_DEGREE_DEFAULT + 2; i++) begin
         add_item(6'd10, COLOR_W'(62 - (i % 63)), 1'b1);
      end
      send_vertex();
   endtask

   task automatic run_drain_pause();
      int i;
      for (i = 0; i < 3; i++) begin
         build_random_vertex();
         send_vertex();
         hold_until_drained();
      end
   endtask

   task automatic run_random_vertices(input int count);
      int target;
      target = items_sent + count;
      while (items_sent < target) begin
         build_random_vertex();
         send_vertex();
      end
   endtask

   task automatic run_steady_stream(input int count);
      calm <= 1'b1;
      run_random_vertices(count);
   endtask

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t mismatch %s expected %0d actual %0d", $time, name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $display("%0t unexpected response expected none actual tdata %h tuser %b tlast %b",
                     $time, rsp_tdata, rsp_tuser, rsp_tlast);
            error_count++;
         end else begin
            oldest_result = expected_results.pop_front();
            check_field("new_color", oldest_result.new_color, rsp_tdata[5:0]);
            check_field("changed", oldest_result.changed, rsp_tdata[6]);
            check_field("reschedule", oldest_result.reschedule, rsp_tdata[7]);
            check_field("neighbor_valid", oldest_result.neighbor_valid, rsp_tuser);
            check_field("end_of_run", oldest_result.end_of_run, rsp_tlast);
         end
      end
   end

   always @(posedge clock) begin
      if (calm) begin
         rsp_tready <= 1'b1;
      end else if (ready_left == 0) begin
         rsp_tready <= 1'($urandom_range(0, 1));
         ready_left <= $urandom_range(1, 11);
      end else begin
         ready_left <= ready_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_empty_vertices();
      run_single_neighbors();
      run_skipped_neighbors();
      run_degree_overflow();
      run_drain_pause();
      run_random_vertices(150);
      run_steady_stream(50);
      hold_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/ffvr_pkg.sv
hw/rtl/ffvr_ram.sv
hw/rtl/ffvr_datapath.sv
hw/rtl/ffvr_ctrl.sv
hw/rtl/first_fit_vertex_recolor.sv
tb/first_fit_vertex_recolor_tb.sv
